// ----- rtl/core/base32_lenient_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Base32 lenient decoder assertion macros
// Shared assertion forms for the decoder; the enclosing module provides clk
// and rst.
// ----------------------------------------------------------------------------
`ifndef BASE32_LENIENT_DECODER_MACROS_SVH
`define BASE32_LENIENT_DECODER_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define B32LD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define B32LD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/b32ld_pkg.sv -----
// ----------------------------------------------------------------------------
// Base32 lenient decoder package
// Types and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package b32ld_pkg;

  // Message status codes, as carried in the status item.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_NO_ROOM  = 2'd2
  } status_t;

  // Hard upper bound on decoded bytes per message.
  localparam logic [23:0] MAX_BYTES = 24'd65535;

  // Depth of the result queue; it must hold at least two entries.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // Character codes with a special meaning.
  localparam logic [7:0] CH_PAD   = 8'h3D; // '='
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_UPPER = 8'h41; // 'A'
  localparam logic [7:0] CH_LOWER = 8'h61; // 'a'
  localparam logic [7:0] CH_TWO   = 8'h32; // '2'
  localparam logic [7:0] DIGIT_BIAS = 8'd26;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic       valid;
    logic       skip;
    logic [4:0] value;
  } sym_t;

  typedef struct packed {
    logic       is_final;
    logic [7:0] data_byte;
    status_t    status;
    logic [15:0] byte_count;
  } result_t;

  // Results produced by one character: count (0..2), then the items in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic           room;
    logic [QAW:0]   fill;
  } qstat_t;

endpackage

// ----- rtl/core/b32ld_sym.sv -----
// ----------------------------------------------------------------------------
// Base32 symbol decode
// Maps one ASCII character to its 5-bit value, or marks it skipped or invalid.
// ----------------------------------------------------------------------------
module b32ld_sym
  import b32ld_pkg::*;
(
  input  logic [7:0] char_in,
  output sym_t       sym
);

  always_comb begin
    sym = '0;
    case (char_in) inside
      [8'h41:8'h5A]: begin
        sym.valid = 1'b1;
        sym.value = 5'(char_in - CH_UPPER);
      end
      [8'h61:8'h7A]: begin
        sym.valid = 1'b1;
        sym.value = 5'(char_in - CH_LOWER);
      end
      [8'h32:8'h37]: begin
        sym.valid = 1'b1;
        sym.value = 5'(char_in - CH_TWO + DIGIT_BIAS);
      end
      CH_PAD, CH_SPACE, CH_LF, CH_CR: begin
        sym.skip = 1'b1;
      end
      default: begin
        sym = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/b32ld_core.sv -----
// ----------------------------------------------------------------------------
// Base32 decode core
// Holds the message state and turns one character into up to two results.
// ----------------------------------------------------------------------------
module b32ld_core
  import b32ld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        step,
  input  in_item_t    item,
  output push_t       push
);

  logic [15:0] out_capacity;
  logic [11:0] acc, acc_next;
  logic [3:0]  held, held_next;
  logic [15:0] count, count_next;
  status_t     err, err_next;

  sym_t        sym;
  logic [23:0] cap_ext, limit;
  logic [11:0] acc_shift;
  logic [3:0]  held_add;
  logic [2:0]  sh;
  logic        emit;
  logic [7:0]  byte_val;
  result_t     data_res, final_res;

  b32ld_sym u_sym (
    .char_in (item.char_in),
    .sym     (sym)
  );

  assign cap_ext   = {8'd0, out_capacity};
  assign limit     = (cap_ext < MAX_BYTES) ? cap_ext : MAX_BYTES;
  assign acc_shift = {acc[6:0], sym.value};
  assign held_add  = held + 4'd5;
  assign sh        = 3'(held_add - 4'd8);
  assign byte_val  = 8'(acc_shift >> sh);

  always_comb begin
    acc_next   = acc;
    held_next  = held;
    count_next = count;
    err_next   = err;
    emit       = 1'b0;
    if (err == ST_OK && !sym.skip) begin
      if (!sym.valid) begin
        err_next = ST_BAD_CHAR;
      end else begin
        acc_next  = acc_shift;
        held_next = held_add;
        if (held_add >= 4'd8) begin
          if ({8'd0, count} >= limit) begin
            err_next = ST_NO_ROOM;
          end else begin
            emit       = 1'b1;
            held_next  = held_add - 4'd8;
            count_next = count + 16'd1;
          end
        end
      end
    end
  end

  always_comb begin
    data_res            = '0;
    data_res.data_byte  = byte_val;
    data_res.status     = ST_OK;
    data_res.byte_count = count_next;
    final_res            = '0;
    final_res.is_final   = 1'b1;
    final_res.status     = err_next;
    final_res.byte_count = count_next;

    push        = '0;
    push.second = final_res;
    if (step) begin
      push.count = 2'(emit) + 2'(item.end_of_message);
      push.first = emit ? data_res : final_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= 16'hFFFF;
      acc          <= '0;
      held         <= '0;
      count        <= '0;
      err          <= ST_OK;
    end else begin
      if (cfg_we) begin
        out_capacity <= cfg_wdata;
      end
      if (step) begin
        if (item.end_of_message) begin
          acc   <= '0;
          held  <= '0;
          count <= '0;
          err   <= ST_OK;
        end else begin
          acc   <= acc_next;
          held  <= held_next;
          count <= count_next;
          err   <= err_next;
        end
      end
    end
  end

endmodule

// ----- rtl/core/b32ld_fifo.sv -----
// ----------------------------------------------------------------------------
// Base32 result queue
// Small register queue taking up to two results a cycle, giving one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module b32ld_fifo
  import b32ld_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output qstat_t  qstat,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head
);

  result_t        mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0]   fill, fill_next;
  logic [QAW-1:0] wp_inc;
  logic           pop;

  assign wp_inc    = wp + QAW'(1);
  assign out_valid = (fill != '0);
  assign pop       = out_valid && out_ready;
  assign head      = mem[rp];
  assign fill_next = fill + (QAW+1)'(push.count) - (QAW+1)'(pop);

  assign qstat.fill = fill;
  assign qstat.room = (fill <= (QAW+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wp] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wp_inc] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      wp   <= wp + QAW'(push.count);
      fill <= fill_next;
      if (pop) begin
        rp <= rp + QAW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/base32_lenient_decoder.sv -----
// ----------------------------------------------------------------------------
// Base32 lenient decoder
// Streaming base32 decoder, one character per beat, bytes and status out.
// ----------------------------------------------------------------------------
// Input channel: one ASCII character per beat on char_in, with end_of_message
// set on the last character of a message. Output channel: one result per
// beat; is_final low carries a decoded byte and its running count, is_final
// high carries the message status (ok, invalid character, capacity exceeded)
// and the total byte count. A character yields no, one or two results.
// cfg_we writes the per-message byte capacity from cfg_wdata; it is meant to
// be written only while the decoder is idle.
// The first result of a character passes the input register and then the
// result queue before it is offered; the input register waits while the queue lacks room.
// The decoder takes one character per cycle for as long as the four-entry
// result queue keeps room for two results; a character that yields two
// results writes both into the queue at once, which then hands them out.
// When the receiver stalls the queue fills and in_ready drops, with nothing
// lost. Synchronous reset empties the pipeline and the queue, clears the
// message state and sets the capacity to 65535.
// ----------------------------------------------------------------------------
module base32_lenient_decoder
  import b32ld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_final,
  output logic [7:0]  data_byte,
  output logic [1:0]  status,
  output logic [15:0] byte_count
);

`include "base32_lenient_decoder_macros.svh"

  // Input register: the character waits here until the queue has room for
  // both results it might produce.
  in_item_t item;
  logic     item_valid;
  logic     step;
  push_t    push;
  qstat_t   qstat;
  result_t  head;

  assign step     = item_valid && qstat.room;
  assign in_ready = !item_valid || qstat.room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.char_in        <= char_in;
      item.end_of_message <= end_of_message;
    end
  end

  // Symbol decode, accumulator and byte count; results go straight into the
  // queue in the same cycle.
  b32ld_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .push      (push)
  );

  b32ld_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .qstat     (qstat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign is_final   = head.is_final;
  assign data_byte  = head.data_byte;
  assign status     = head.status;
  assign byte_count = head.byte_count;

  // The queue never holds more than its depth.
  `B32LD_ASSERT_IMPL(a_fill_bound, 1'b1, qstat.fill <= (QAW+1)'(QDEPTH),
    "result queue overfilled")
  // Back-pressure only when a character is waiting and the queue is short of room.
  `B32LD_ASSERT_IMPL(a_stall_cause, !in_ready,
    item_valid && (qstat.fill > (QAW+1)'(QDEPTH - 2)), "input stalled without cause")
  // A data byte always reports ok and counts itself.
  `B32LD_ASSERT_IMPL(a_data_item, out_valid && !is_final,
    (status == ST_OK) && (byte_count != 16'd0), "malformed data result")

endmodule

// ----- sim/tb_base32_lenient_decoder.sv -----
// ----------------------------------------------------------------------------
// Base32 lenient decoder testbench
// Drives base32 characters through the decoder with random gaps on both
// channels. Each accepted character is run through an independent decoder
// model, and every result beat is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_base32_lenient_decoder
  import b32ld_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any beat on either channel before the run is abandoned.
  // The longest legitimate quiet spell is a drain wait plus a few random
  // gaps, so this is far beyond anything a working decoder needs.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 520;
  localparam int unsigned PHASE_ITEMS = 70;
  // Covers the wait from an input beat to its first result with margin.
  localparam int unsigned SETTLE_CYCLES = 8;

  // Typed-in status results for the directed table.
  localparam result_t BAD_EMPTY  = '{1'b1, 8'h00, ST_BAD_CHAR, 16'd0};
  localparam result_t OK_EMPTY   = '{1'b1, 8'h00, ST_OK, 16'd0};
  localparam result_t ROOM_EMPTY = '{1'b1, 8'h00, ST_NO_ROOM, 16'd0};

  typedef struct {
    logic        wr_cap;   // row is a capacity write, not a character
    logic [15:0] cap;
    logic [7:0]  ch;
    logic        eom;
    logic        typed;    // expected result given in the row itself
    result_t     want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  char_in = 8'd0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        is_final;
  logic [7:0]  data_byte;
  logic [1:0]  status;
  logic [15:0] byte_count;

  // Model state of the decoder, mirroring the register and message state.
  logic [15:0] dec_cap   = 16'hFFFF;
  logic [11:0] dec_acc   = 12'd0;
  logic [3:0]  dec_held  = 4'd0;
  logic [15:0] dec_count = 16'd0;
  status_t     dec_err   = ST_OK;

  result_t     expected_results[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  // While calm is set neither side inserts gaps.
  logic        calm = 1'b0;

  base32_lenient_decoder u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_in        (char_in),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_final       (is_final),
    .data_byte      (data_byte),
    .status         (status),
    .byte_count     (byte_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decodes one character in the model and returns the number of results it
  // causes (0..2), which are written to r0 and r1 in order.
  function automatic int decode_char(input logic [7:0] c, input logic eom,
                                     output result_t r0, output result_t r1);
    result_t     res[2];
    int          n;
    logic [4:0]  v;
    logic        is_sym;
    logic [15:0] limit;
    logic [11:0] shifted;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    v = 5'd0;
    limit = ({8'd0, dec_cap} < MAX_BYTES) ? dec_cap : MAX_BYTES[15:0];
    // Padding and white space are skipped; once an error is held nothing
    // but the end of the message has any effect.
    if (dec_err == ST_OK &&
        !(c == CH_PAD || c == CH_SPACE || c == CH_LF || c == CH_CR)) begin
      is_sym = 1'b1;
      if (c >= CH_UPPER && c <= CH_UPPER + 8'd25) begin
        v = 5'(c - CH_UPPER);
      end else if (c >= CH_LOWER && c <= CH_LOWER + 8'd25) begin
        v = 5'(c - CH_LOWER);
      end else if (c >= CH_TWO && c <= CH_TWO + 8'd5) begin
        v = 5'(c - CH_TWO + DIGIT_BIAS);
      end else begin
        is_sym = 1'b0;
      end
      if (!is_sym) begin
        dec_err = ST_BAD_CHAR;
      end else begin
        dec_acc = {dec_acc[6:0], v};
        dec_held = dec_held + 4'd5;
        if (dec_held >= 4'd8) begin
          if (dec_count >= limit) begin
            // No room for the completed byte: it is dropped and the
            // capacity error sticks until the end of the message.
            dec_err = ST_NO_ROOM;
          end else begin
            shifted = dec_acc >> (dec_held - 4'd8);
            dec_held = dec_held - 4'd8;
            dec_count = dec_count + 16'd1;
            res[n] = '{1'b0, shifted[7:0], ST_OK, dec_count};
            n++;
          end
        end
      end
    end
    if (eom) begin
      // The status beat closes the message; leftover bits are dropped.
      res[n] = '{1'b1, 8'h00, dec_err, dec_count};
      n++;
      dec_acc = 12'd0;
      dec_held = 4'd0;
      dec_count = 16'd0;
      dec_err = ST_OK;
    end
    r0 = res[0];
    r1 = res[1];
    return n;
  endfunction

  // Appends one result to the tail of the expectation queue.
  function automatic void add_expected(input result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Offers one character, waits for the input beat, then records what the
  // model expects from it (or the row's own expectation when typed is set).
  task automatic send_char(input logic [7:0] c, input logic eom,
                           input logic typed, input result_t want);
    result_t r0;
    result_t r1;
    int      n;
    if (!calm) begin
      while ($urandom_range(99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    char_in <= c;
    end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = decode_char(c, eom, r0, r1);
    if (typed) begin
      add_expected(want);
    end else begin
      if (n > 0) add_expected(r0);
      if (n > 1) add_expected(r1);
    end
  endtask

  // Holds the sender back until every expected result has arrived, then waits
  // so that characters that cause no result clear the pipeline.
  task automatic drain_decoder();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The capacity register is only written with the decoder idle.
  task automatic set_capacity(input logic [15:0] cap);
    drain_decoder();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    dec_cap = cap;
  endtask

  // A character for a well-formed message: mostly alphabet symbols in either
  // case, with the occasional padding or white space that must be skipped.
  function automatic logic [7:0] pick_symbol();
    int unsigned r;
    logic [7:0]  ch;
    r = $urandom_range(99);
    if (r < 8) begin
      case ($urandom_range(3))
        0: ch = CH_PAD;
        1: ch = CH_SPACE;
        2: ch = CH_LF;
        default: ch = CH_CR;
      endcase
    end else begin
      r = $urandom_range(31);
      if (r >= 26) ch = CH_TWO + 8'(r - 26);
      else ch = ($urandom_range(1) ? CH_UPPER : CH_LOWER) + 8'(r);
    end
    return ch;
  endfunction

  // Result side: random back-pressure, and every result beat is checked
  // against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat: final %0d byte %02h status %0d count %0d",
                   $time, is_final, data_byte, status, byte_count);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (is_final !== want.is_final || data_byte !== want.data_byte ||
              status !== 2'(want.status) || byte_count !== want.byte_count) begin
            $display("%0t: result mismatch: expected final %0d byte %02h status %0d count %0d",
                     $time, want.is_final, want.data_byte, want.status, want.byte_count);
            $display("%0t:                   actual final %0d byte %02h status %0d count %0d",
                     $time, is_final, data_byte, status, byte_count);
            mismatches++;
          end
        end
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
    end
  end

  // Watchdog: any beat on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t    dir_rows[$];
    int unsigned rand_items;
    int unsigned phase_items;
    int unsigned phase;
    int unsigned msg_kind;
    int unsigned msg_len;
    int unsigned bad_pos;
    logic [15:0] new_cap;
    logic [7:0]  c;

    // Directed table. Status beats that follow straight from reset, from an
    // error or from an extreme character are typed in; rows that carry data
    // are left to the model.
    dir_rows = '{
      // Invalid character straight after reset, and a message of padding only.
      '{1'b0, 16'd0, "!", 1'b1, 1'b1, BAD_EMPTY},
      '{1'b0, 16'd0, "=", 1'b1, 1'b1, OK_EMPTY},
      // Extremes of the character field.
      '{1'b0, 16'd0, 8'h00, 1'b1, 1'b1, BAD_EMPTY},
      '{1'b0, 16'd0, 8'hFF, 1'b1, 1'b1, BAD_EMPTY},
      // Just outside the upper-case range.
      '{1'b0, 16'd0, "@", 1'b1, 1'b1, BAD_EMPTY},
      // A valid character after an error is ignored, error kept to the end.
      '{1'b0, 16'd0, "[", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "A", 1'b1, 1'b1, BAD_EMPTY},
      // Range ends of every symbol class with skipped characters in between;
      // the last symbol leaves bits over, which are dropped.
      '{1'b0, 16'd0, "A", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "z", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "2", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, " ", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "7", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, CH_CR, 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "Z", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, CH_LF, 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "a", 1'b1, 1'b0, '0},
      // Zero capacity: the first complete byte raises the capacity error.
      '{1'b1, 16'd0, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "A", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "A", 1'b1, 1'b1, ROOM_EMPTY},
      // Capacity of one: one byte gets out, the next hits the limit.
      '{1'b1, 16'd1, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "7", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "7", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "7", 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "7", 1'b1, 1'b0, '0},
      // Back to full capacity; digits and brackets just outside the alphabet
      // (8'h60 is the grave accent just below the lower-case range).
      '{1'b1, 16'hFFFF, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, 16'd0, "1", 1'b1, 1'b1, BAD_EMPTY},
      '{1'b0, 16'd0, "8", 1'b1, 1'b1, BAD_EMPTY},
      '{1'b0, 16'd0, 8'h60, 1'b1, 1'b1, BAD_EMPTY},
      '{1'b0, 16'd0, "{", 1'b1, 1'b1, BAD_EMPTY}
    };

    // Reset is held from the start and released on a rising edge.
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cap) begin
        set_capacity(dir_rows[i].cap);
      end else begin
        send_char(dir_rows[i].ch, dir_rows[i].eom, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random part, in phases of differing capacity. Most messages are well
    // formed with random content; some carry one stray byte, and a few are
    // pure noise. The middle of the run has no gaps on either side.
    rand_items = 0;
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case (phase)
        0: new_cap = 16'hFFFF;
        1: new_cap = 16'd0;
        2: new_cap = 16'd1;
        3: new_cap = 16'($urandom_range(2, 12));
        4: new_cap = 16'($urandom);
        5: new_cap = 16'hFFFF;
        default: new_cap = 16'($urandom_range(0, 24));
      endcase
      set_capacity(new_cap);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && rand_items < RANDOM_ITEMS) begin
        msg_kind = $urandom_range(99);
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
        bad_pos = $urandom_range(msg_len - 1);
        for (int unsigned i = 0; i < msg_len; i++) begin
          if (msg_kind >= 90 || (msg_kind >= 75 && i == bad_pos)) c = 8'($urandom_range(255));
          else c = pick_symbol();
          send_char(c, i == msg_len - 1, 1'b0, '0);
          phase_items++;
          rand_items++;
          calm = (rand_items >= 200 && rand_items < 320);
        end
      end
      phase++;
    end

    // Everything is offered; wait for the last results and a little more.
    drain_decoder();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
